/* rtl/core/cru_pkg.sv */
package cru_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int KEY_W = 64;
  localparam int CAP_W = 37;
  localparam int USE_W = CAP_W + 1;
  localparam int REF_W = 16;
  localparam int QDEPTH = ENTRIES + 2;
  localparam int QPTR_W = $clog2(QDEPTH + 1);

  localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

  typedef enum logic [2:0] {
    OP_INSERT      = 3'd0,
    OP_LOOKUP      = 3'd1,
    OP_RELEASE     = 3'd2,
    OP_ERASE       = 3'd3,
    OP_TRIM        = 3'd4,
    OP_ERASE_UNREF = 3'd5
  } op_e;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_REJECTED   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_NO_SLOT    = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;
  localparam logic [2:0] ST_REF_OVF    = 3'd5;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_FREED = 1'b1;

  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_STRICT   = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [31:0]      hash;
    logic [31:0]      value;
    logic [31:0]      charge;
  } ent_t;

  typedef struct packed {
    logic             kind;
    logic [2:0]       status;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] key;
    logic [31:0]      value;
    logic [31:0]      charge;
    logic             last;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
    logic drain;
    logic clr;
  } q_ctl_t;

  function automatic logic [USE_W-1:0] sub_sat(input logic [USE_W-1:0] a,
                                               input logic [USE_W-1:0] b);
    return (a >= b) ? a - b : '0;
  endfunction

  function automatic logic [CAP_W-1:0] sat_out(input logic [USE_W-1:0] a);
    return a[USE_W-1] ? {CAP_W{1'b1}} : a[CAP_W-1:0];
  endfunction

endpackage

/* rtl/core/cru_ram.sv */
module cru_ram #(
  parameter int Width = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [cru_pkg::IDX_W-1:0]  waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [cru_pkg::IDX_W-1:0]  raddr_i,
  output logic [Width-1:0]           rdata_o
);

  logic [Width-1:0] mem [cru_pkg::ENTRIES];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/cru_ctrl.sv */
module cru_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [cru_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [31:0]                   key_hash_i,
  input  logic [31:0]                   new_value_i,
  input  logic [31:0]                   charge_i,
  input  logic                          want_handle_i,
  input  logic [cru_pkg::IDX_W-1:0]     handle_slot_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cru_pkg::CAP_W-1:0]     cfg_data_i,
  output cru_pkg::q_ctl_t               q_ctl_o,
  input  logic                          q_busy_i,
  output logic [cru_pkg::CAP_W-1:0]     usage_o,
  output logic [cru_pkg::CAP_W-1:0]     pinned_usage_o
);

  localparam int N = cru_pkg::ENTRIES;
  localparam int IW = cru_pkg::IDX_W;
  localparam int UW = cru_pkg::USE_W;
  localparam int RW = cru_pkg::REF_W;

  typedef enum logic [3:0] {
    S_IDLE, S_EV_CHK, S_EV_DO, S_INS_CHK, S_FIND, S_INS_WR, S_OLD_DO,
    S_LK_DO, S_ER_DO, S_RL_DO, S_APPEND, S_REPLY, S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic [2:0] op_q, op_d;
  logic [cru_pkg::KEY_W-1:0] key_q, key_d;
  logic [31:0] hash_q, hash_d, val_q, val_d, chg_q, chg_d;
  logic want_q, want_d;
  logic [cru_pkg::CAP_W-1:0] capacity_q, capacity_d;
  logic strict_q, strict_d;
  logic [N-1:0] valid_q, valid_d, intab_q, intab_d;
  logic [IW-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic empty_q, empty_d;
  logic [UW-1:0] total_q, total_d, lrut_q, lrut_d;
  logic [IW-1:0] tgt_q, tgt_d, fr_q, fr_d, sc_q, sc_d, cidx_q, cidx_d;
  logic found_q, found_d, cmpv_q, cmpv_d;
  logic [2:0] st_q, st_d;
  logic [IW-1:0] rslot_q, rslot_d, app_q, app_d;
  logic [31:0] rval_q, rval_d, appc_q, appc_d;

  logic [IW-1:0] rd_addr;
  logic ent_we, refs_we, prev_we, next_we;
  logic [IW-1:0] ent_wa, refs_wa, prev_wa, next_wa;
  cru_pkg::ent_t ent_wd, ent_rd;
  logic [RW-1:0] refs_wd, refs_rd, rdec;
  logic [IW-1:0] prev_wd, prev_rd, next_wd, next_rd;

  logic do_rm, do_free, fr_any, match, over;
  logic [IW-1:0] fr_idx;
  logic [UW-1:0] need, pinned;

  cru_ram #(.Width($bits(cru_pkg::ent_t))) u_ent (
    .clk_i, .we_i(ent_we), .waddr_i(ent_wa), .wdata_i(ent_wd),
    .raddr_i(rd_addr), .rdata_o(ent_rd)
  );
  cru_ram #(.Width(RW)) u_refs (
    .clk_i, .we_i(refs_we), .waddr_i(refs_wa), .wdata_i(refs_wd),
    .raddr_i(rd_addr), .rdata_o(refs_rd)
  );
  cru_ram #(.Width(IW)) u_prev (
    .clk_i, .we_i(prev_we), .waddr_i(prev_wa), .wdata_i(prev_wd),
    .raddr_i(rd_addr), .rdata_o(prev_rd)
  );
  cru_ram #(.Width(IW)) u_next (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(rd_addr), .rdata_o(next_rd)
  );

  always_comb begin
    fr_any = 1'b0;
    fr_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        fr_any = 1'b1;
        fr_idx = IW'(i);
      end
    end
  end

  assign need = (op_q == cru_pkg::OP_INSERT) ? {{(UW-32){1'b0}}, chg_q} : '0;
  assign over = (total_q + need) > {1'b0, capacity_q};
  assign pinned = cru_pkg::sub_sat(total_q, lrut_q);
  assign match = cmpv_q && valid_q[cidx_q] && intab_q[cidx_q] &&
                 ent_rd.hash == hash_q && ent_rd.key == key_q;
  assign rdec = (refs_rd == '0) ? '0 : refs_rd - RW'(1);

  always_comb begin
    state_d = state_q;
    op_d = op_q; key_d = key_q; hash_d = hash_q; val_d = val_q; chg_d = chg_q;
    want_d = want_q;
    capacity_d = capacity_q; strict_d = strict_q;
    valid_d = valid_q; intab_d = intab_q;
    oldest_d = oldest_q; newest_d = newest_q; empty_d = empty_q;
    total_d = total_q; lrut_d = lrut_q;
    tgt_d = tgt_q; fr_d = fr_q; sc_d = sc_q; cidx_d = cidx_q;
    found_d = found_q; cmpv_d = cmpv_q;
    st_d = st_q; rslot_d = rslot_q; rval_d = rval_q; app_d = app_q; appc_d = appc_q;
    rd_addr = tgt_q;
    ent_we = 1'b0; ent_wa = fr_q;
    ent_wd = '{key: key_q, hash: hash_q, value: val_q, charge: chg_q};
    refs_we = 1'b0; refs_wa = tgt_q; refs_wd = rdec;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    do_rm = 1'b0; do_free = 1'b0;
    q_ctl_o = '0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cru_pkg::CFG_CAPACITY: capacity_d = cfg_data_i;
        cru_pkg::CFG_STRICT:   strict_d = cfg_data_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = opcode_i; key_d = entry_key_i; hash_d = key_hash_i;
          val_d = new_value_i; chg_d = charge_i; want_d = want_handle_i;
          st_d = cru_pkg::ST_OK; rslot_d = '0; rval_d = '0;
          sc_d = '0; cmpv_d = 1'b0; found_d = 1'b0;
          unique case (opcode_i)
            cru_pkg::OP_INSERT, cru_pkg::OP_TRIM, cru_pkg::OP_ERASE_UNREF:
              state_d = S_EV_CHK;
            cru_pkg::OP_LOOKUP, cru_pkg::OP_ERASE: state_d = S_FIND;
            cru_pkg::OP_RELEASE: begin
              rd_addr = handle_slot_i;
              tgt_d = handle_slot_i;
              state_d = S_RL_DO;
            end
            default: state_d = S_REPLY;
          endcase
        end
      end
      S_EV_CHK: begin
        if (!empty_q && (op_q == cru_pkg::OP_ERASE_UNREF || over)) begin
          rd_addr = oldest_q;
          tgt_d = oldest_q;
          state_d = S_EV_DO;
        end else if (op_q == cru_pkg::OP_INSERT) begin
          state_d = S_INS_CHK;
        end else begin
          state_d = S_REPLY;
        end
      end
      S_EV_DO: begin
        do_free = 1'b1;
        if (oldest_q == newest_q) empty_d = 1'b1;
        else oldest_d = next_rd;
        lrut_d = cru_pkg::sub_sat(lrut_q, {{(UW-32){1'b0}}, ent_rd.charge});
        total_d = cru_pkg::sub_sat(total_q, {{(UW-32){1'b0}}, ent_rd.charge});
        state_d = S_EV_CHK;
      end
      S_INS_CHK: begin
        if (strict_q && (pinned + {{(UW-32){1'b0}}, chg_q}) > {1'b0, capacity_q}) begin
          st_d = cru_pkg::ST_REJECTED;
          if (!want_q) begin
            q_ctl_o.push = 1'b1;
            q_ctl_o.rec = '{kind: cru_pkg::KIND_FREED, status: cru_pkg::ST_OK,
                            slot: '0, key: key_q, value: val_q, charge: chg_q,
                            last: 1'b0};
          end
          state_d = S_REPLY;
        end else if (!fr_any) begin
          st_d = cru_pkg::ST_NO_SLOT;
          state_d = S_REPLY;
        end else begin
          fr_d = fr_idx;
          state_d = S_FIND;
        end
      end
      S_FIND: begin
        rd_addr = sc_q;
        if (match) begin
          found_d = 1'b1;
          tgt_d = cidx_q;
          rd_addr = cidx_q;
          if (op_q == cru_pkg::OP_INSERT) state_d = S_INS_WR;
          else if (op_q == cru_pkg::OP_LOOKUP) state_d = S_LK_DO;
          else state_d = S_ER_DO;
        end else if (cmpv_q && cidx_q == IW'(N - 1)) begin
          if (op_q == cru_pkg::OP_INSERT) begin
            state_d = S_INS_WR;
          end else begin
            st_d = cru_pkg::ST_NOT_FOUND;
            state_d = S_REPLY;
          end
        end else begin
          cidx_d = sc_q;
          cmpv_d = 1'b1;
          sc_d = sc_q + IW'(1);
        end
      end
      S_INS_WR: begin
        ent_we = 1'b1;
        refs_we = 1'b1;
        refs_wa = fr_q;
        refs_wd = want_q ? RW'(2) : RW'(1);
        valid_d[fr_q] = 1'b1;
        intab_d[fr_q] = 1'b1;
        total_d = total_q + {{(UW-32){1'b0}}, chg_q};
        rslot_d = fr_q;
        app_d = fr_q;
        appc_d = chg_q;
        if (found_q) state_d = S_OLD_DO;
        else if (!want_q) state_d = S_APPEND;
        else state_d = S_REPLY;
      end
      S_OLD_DO: begin
        intab_d[tgt_q] = 1'b0;
        refs_we = 1'b1;
        if (rdec == '0) begin
          total_d = cru_pkg::sub_sat(total_q, {{(UW-32){1'b0}}, ent_rd.charge});
          do_free = 1'b1;
          do_rm = (refs_rd == RW'(1));
        end
        state_d = want_q ? S_REPLY : S_APPEND;
      end
      S_LK_DO: begin
        rslot_d = tgt_q;
        rval_d = ent_rd.value;
        if (refs_rd == cru_pkg::REF_MAX) begin
          st_d = cru_pkg::ST_REF_OVF;
        end else begin
          do_rm = (refs_rd == RW'(1));
          refs_we = 1'b1;
          refs_wd = refs_rd + RW'(1);
        end
        state_d = S_REPLY;
      end
      S_ER_DO: begin
        if (refs_rd == RW'(1)) begin
          do_rm = 1'b1;
          do_free = 1'b1;
          total_d = cru_pkg::sub_sat(total_q, {{(UW-32){1'b0}}, ent_rd.charge});
        end else begin
          refs_we = 1'b1;
          intab_d[tgt_q] = 1'b0;
        end
        state_d = S_REPLY;
      end
      S_RL_DO: begin
        state_d = S_REPLY;
        if (!valid_q[tgt_q] || refs_rd == '0 ||
            (intab_q[tgt_q] && refs_rd <= RW'(1))) begin
          st_d = cru_pkg::ST_BAD_HANDLE;
        end else begin
          rslot_d = tgt_q;
          refs_we = 1'b1;
          if (rdec == '0) begin
            total_d = cru_pkg::sub_sat(total_q, {{(UW-32){1'b0}}, ent_rd.charge});
            do_free = 1'b1;
          end else if (rdec == RW'(1) && intab_q[tgt_q]) begin
            if (total_q > {1'b0, capacity_q}) begin
              total_d = cru_pkg::sub_sat(total_q, {{(UW-32){1'b0}}, ent_rd.charge});
              do_free = 1'b1;
            end else begin
              app_d = tgt_q;
              appc_d = ent_rd.charge;
              state_d = S_APPEND;
            end
          end
        end
      end
      S_APPEND: begin
        if (empty_q) begin
          oldest_d = app_q;
          empty_d = 1'b0;
        end else begin
          next_we = 1'b1; next_wa = newest_q; next_wd = app_q;
          prev_we = 1'b1; prev_wa = app_q; prev_wd = newest_q;
        end
        newest_d = app_q;
        lrut_d = lrut_q + {{(UW-32){1'b0}}, appc_q};
        state_d = S_REPLY;
      end
      S_REPLY: begin
        q_ctl_o.push = 1'b1;
        q_ctl_o.rec = '{kind: cru_pkg::KIND_REPLY, status: st_q, slot: rslot_q,
                        key: '0, value: rval_q, charge: '0, last: 1'b1};
        state_d = S_DRAIN;
      end
      S_DRAIN: begin
        q_ctl_o.drain = 1'b1;
        if (!q_busy_i) begin
          q_ctl_o.clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (do_rm) begin
      if (oldest_q == tgt_q && newest_q == tgt_q) begin
        empty_d = 1'b1;
      end else if (oldest_q == tgt_q) begin
        oldest_d = next_rd;
      end else if (newest_q == tgt_q) begin
        newest_d = prev_rd;
      end else begin
        next_we = 1'b1; next_wa = prev_rd; next_wd = next_rd;
        prev_we = 1'b1; prev_wa = next_rd; prev_wd = prev_rd;
      end
      lrut_d = cru_pkg::sub_sat(lrut_q, {{(UW-32){1'b0}}, ent_rd.charge});
    end

    if (do_free) begin
      valid_d[tgt_q] = 1'b0;
      intab_d[tgt_q] = 1'b0;
      q_ctl_o.push = 1'b1;
      q_ctl_o.rec = '{kind: cru_pkg::KIND_FREED, status: cru_pkg::ST_OK,
                      slot: tgt_q, key: ent_rd.key, value: ent_rd.value,
                      charge: ent_rd.charge, last: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= '0; key_q <= '0; hash_q <= '0; val_q <= '0; chg_q <= '0;
      want_q <= 1'b0;
      capacity_q <= '0; strict_q <= 1'b0;
      valid_q <= '0; intab_q <= '0;
      oldest_q <= '0; newest_q <= '0; empty_q <= 1'b1;
      total_q <= '0; lrut_q <= '0;
      tgt_q <= '0; fr_q <= '0; sc_q <= '0; cidx_q <= '0;
      found_q <= 1'b0; cmpv_q <= 1'b0;
      st_q <= '0; rslot_q <= '0; rval_q <= '0; app_q <= '0; appc_q <= '0;
    end else begin
      state_q <= state_d;
      op_q <= op_d; key_q <= key_d; hash_q <= hash_d; val_q <= val_d; chg_q <= chg_d;
      want_q <= want_d;
      capacity_q <= capacity_d; strict_q <= strict_d;
      valid_q <= valid_d; intab_q <= intab_d;
      oldest_q <= oldest_d; newest_q <= newest_d; empty_q <= empty_d;
      total_q <= total_d; lrut_q <= lrut_d;
      tgt_q <= tgt_d; fr_q <= fr_d; sc_q <= sc_d; cidx_q <= cidx_d;
      found_q <= found_d; cmpv_q <= cmpv_d;
      st_q <= st_d; rslot_q <= rslot_d; rval_q <= rval_d; app_q <= app_d;
      appc_q <= appc_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign usage_o = cru_pkg::sat_out(total_q);
  assign pinned_usage_o = cru_pkg::sat_out(pinned);

  a_empty_lru_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q |-> lrut_q == '0) else $error("empty LRU order holds charge");

  a_lru_within_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lrut_q <= total_q) else $error("LRU charge exceeds total usage");

  a_idle_queue_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_busy_i |-> state_q != S_IDLE) else $error("results pending while idle");

endmodule

/* rtl/core/cru_rq.sv */
module cru_rq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cru_pkg::q_ctl_t  q_ctl_i,
  output logic             q_busy_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cru_pkg::rec_t    rec_o
);

  localparam int PW = cru_pkg::QPTR_W;

  cru_pkg::rec_t mem [cru_pkg::QDEPTH];
  cru_pkg::rec_t rd_q;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic out_valid_q, out_valid_d;
  logic issue;

  assign issue = q_ctl_i.drain && (rd_ptr_q != wr_ptr_q) && !out_valid_q;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (q_ctl_i.push) wr_ptr_d = wr_ptr_q + PW'(1);
    if (issue) rd_ptr_d = rd_ptr_q + PW'(1);
    if (q_ctl_i.clr) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
    end
    out_valid_d = issue | (out_valid_q & out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (q_ctl_i.push) begin
      mem[wr_ptr_q] <= q_ctl_i.rec;
    end
    if (issue) begin
      rd_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign q_busy_o = (rd_ptr_q != wr_ptr_q) | out_valid_q;
  assign out_valid_o = out_valid_q;
  assign rec_o = rd_q;

endmodule

/* rtl/core/refcounted_lru_charge_cache_unit.sv */
// Work per item: the key search walks one slot per cycle through the entry
// RAM, evictions are done one at a time before the insert, and the results
// then drain through the result queue; one item at a time.
// Throughput: next item is taken once every result of the current one is delivered.
// Reset: all slots free, LRU order empty, usages, capacity and strict mode zero.
module refcounted_lru_charge_cache_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    opcode_i,
  input  logic [cru_pkg::KEY_W-1:0]     entry_key_i,
  input  logic [31:0]                   key_hash_i,
  input  logic [31:0]                   new_value_i,
  input  logic [31:0]                   charge_i,
  input  logic                          want_handle_i,
  input  logic [cru_pkg::IDX_W-1:0]     handle_slot_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [cru_pkg::CAP_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          result_kind_o,
  output logic [2:0]                    status_o,
  output logic [cru_pkg::IDX_W-1:0]     slot_o,
  output logic [cru_pkg::KEY_W-1:0]     out_key_o,
  output logic [31:0]                   out_value_o,
  output logic [31:0]                   out_charge_o,
  output logic [cru_pkg::CAP_W-1:0]     usage_o,
  output logic [cru_pkg::CAP_W-1:0]     pinned_usage_o,
  output logic                          last_o
);

  cru_pkg::q_ctl_t q_ctl;
  cru_pkg::rec_t   rec;
  logic            q_busy;

  cru_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .entry_key_i,
    .key_hash_i, .new_value_i, .charge_i, .want_handle_i, .handle_slot_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_ctl_o(q_ctl), .q_busy_i(q_busy), .usage_o, .pinned_usage_o
  );

  cru_rq u_rq (
    .clk_i, .rst_ni, .q_ctl_i(q_ctl), .q_busy_o(q_busy),
    .out_valid_o, .out_stall_i, .rec_o(rec)
  );

  assign result_kind_o = rec.kind;
  assign status_o = rec.status;
  assign slot_o = rec.slot;
  assign out_key_o = rec.key;
  assign out_value_o = rec.value;
  assign out_charge_o = rec.charge;
  assign last_o = rec.last;

endmodule
